@@ hw/rtl/tbmt_pkg.sv @@
`default_nettype none
package tbmt_pkg;

  // register data and index
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BATCHES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_TILES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd2;

  // field and geometry widths, sized for the widest tile shape
  localparam int BATCHES_W = 11;
  localparam int BIDX_W    = 10;
  localparam int RTILES_W  = 8;
  localparam int RTIDX_W   = 7;
  localparam int COLS_W    = 13;
  localparam int FULL_W    = 12;
  localparam int REM_W     = 7;
  localparam int TW_W      = 8;
  localparam int ROWS_W    = 15;
  localparam int CSTEP_W   = 22;
  localparam int BSTEP_W   = 28;
  localparam int DEST_W    = 34;
  localparam int VAL_W     = 32;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_OUT     = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic             command;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [VAL_W-1:0]  value_res;
    logic [DEST_W-1:0] dest_index;
    logic              last_of_tile;
    logic              last_of_tensor;
  } res_t;

  // tensor geometry handed to the tile walker
  typedef struct packed {
    logic [BATCHES_W-1:0] batches;
    logic [RTILES_W-1:0]  row_tiles;
    logic [FULL_W-1:0]    full_tiles;
    logic [REM_W-1:0]     rem_width;
    logic                 full_zero;
    logic [ROWS_W-1:0]    rows;
    logic [CSTEP_W-1:0]   col_step;
    logic [BSTEP_W-1:0]   batch_step;
    logic                 restart;
    logic                 restart_rem;
  } geom_t;

  // per-request result info, value comes later from the store
  typedef struct packed {
    logic [1:0]        status;
    logic [DEST_W-1:0] dest_index;
    logic              last_of_tile;
    logic              last_of_tensor;
  } meta_t;

endpackage
`default_nettype wire

@@ hw/rtl/tbmt_ram.sv @@
`default_nettype none
module tbmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tbmt_cfg.sv @@
`default_nettype none
module tbmt_cfg #(
  parameter int TILE_ROWS = 32,
  parameter int TILE_COLS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [tbmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tbmt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tbmt_pkg::geom_t                        geom
);

  // reciprocal for cols / TILE_COLS, exact for 13-bit dividends
  localparam int DIV_SHIFT = 20;
  localparam int DIV_MULT  = (2**DIV_SHIFT + TILE_COLS - 1) / TILE_COLS;
  localparam int PROD_W    = tbmt_pkg::COLS_W + DIV_SHIFT;
  localparam logic [tbmt_pkg::FULL_W-1:0] RESET_FULL = tbmt_pkg::FULL_W'(32 / TILE_COLS);
  localparam logic [tbmt_pkg::REM_W-1:0]  RESET_REM  = tbmt_pkg::REM_W'(32 % TILE_COLS);

  logic [tbmt_pkg::BATCHES_W-1:0] batches;
  logic [tbmt_pkg::RTILES_W-1:0]  row_tiles;
  logic [tbmt_pkg::COLS_W-1:0]    cols;
  logic [tbmt_pkg::FULL_W-1:0]    full_tiles;
  logic [tbmt_pkg::REM_W-1:0]     rem_width;
  logic [tbmt_pkg::ROWS_W-1:0]    rows;
  logic [tbmt_pkg::CSTEP_W-1:0]   col_step;
  logic [tbmt_pkg::BSTEP_W-1:0]   batch_step;

  logic [tbmt_pkg::BATCHES_W-1:0] batches_c;
  logic [tbmt_pkg::RTILES_W-1:0]  row_tiles_c;
  logic [tbmt_pkg::COLS_W-1:0]    cols_c;
  logic [PROD_W-1:0]              div_prod;
  logic [tbmt_pkg::FULL_W-1:0]    quot;
  logic [tbmt_pkg::COLS_W-1:0]    quot_x_tile;
  logic [tbmt_pkg::REM_W-1:0]     rem_c;
  logic                           hit;

  // clamp written values into their ranges
  always_comb begin
    if (cfg_data == '0) begin
      batches_c = tbmt_pkg::BATCHES_W'(1);
    end else if (cfg_data > tbmt_pkg::CFG_DATA_W'(1024)) begin
      batches_c = tbmt_pkg::BATCHES_W'(1024);
    end else begin
      batches_c = tbmt_pkg::BATCHES_W'(cfg_data);
    end
    if (cfg_data == '0) begin
      row_tiles_c = tbmt_pkg::RTILES_W'(1);
    end else if (cfg_data > tbmt_pkg::CFG_DATA_W'(128)) begin
      row_tiles_c = tbmt_pkg::RTILES_W'(128);
    end else begin
      row_tiles_c = tbmt_pkg::RTILES_W'(cfg_data);
    end
    if (cfg_data == '0) begin
      cols_c = tbmt_pkg::COLS_W'(1);
    end else if (cfg_data > tbmt_pkg::CFG_DATA_W'(4096)) begin
      cols_c = tbmt_pkg::COLS_W'(4096);
    end else begin
      cols_c = cfg_data;
    end
  end

  assign div_prod    = PROD_W'(cols_c) * PROD_W'(DIV_MULT);
  assign quot        = tbmt_pkg::FULL_W'(div_prod >> DIV_SHIFT);
  assign quot_x_tile = tbmt_pkg::COLS_W'(quot) * tbmt_pkg::COLS_W'(TILE_COLS);
  assign rem_c       = tbmt_pkg::REM_W'(cols_c - quot_x_tile);

  assign hit = cfg_we && (cfg_index == tbmt_pkg::CFG_BATCHES ||
                          cfg_index == tbmt_pkg::CFG_ROW_TILES ||
                          cfg_index == tbmt_pkg::CFG_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      batches    <= tbmt_pkg::BATCHES_W'(1);
      row_tiles  <= tbmt_pkg::RTILES_W'(1);
      cols       <= tbmt_pkg::COLS_W'(32);
      full_tiles <= RESET_FULL;
      rem_width  <= RESET_REM;
    end else if (cfg_we) begin
      case (cfg_index)
        tbmt_pkg::CFG_BATCHES: begin
          batches <= batches_c;
        end
        tbmt_pkg::CFG_ROW_TILES: begin
          row_tiles <= row_tiles_c;
        end
        tbmt_pkg::CFG_COLS: begin
          cols       <= cols_c;
          full_tiles <= quot;
          rem_width  <= rem_c;
        end
        default: begin
        end
      endcase
    end
  end

  // rows and step sizes are registered, settling well before the first tile ends
  always_ff @(posedge clk) begin
    rows       <= tbmt_pkg::ROWS_W'(row_tiles) * tbmt_pkg::ROWS_W'(TILE_ROWS);
    col_step   <= tbmt_pkg::CSTEP_W'(rows) * tbmt_pkg::CSTEP_W'(TILE_COLS);
    batch_step <= tbmt_pkg::BSTEP_W'(cols) * tbmt_pkg::BSTEP_W'(rows);
  end

  always_comb begin
    geom.batches     = batches;
    geom.row_tiles   = row_tiles;
    geom.full_tiles  = full_tiles;
    geom.rem_width   = rem_width;
    geom.full_zero   = (full_tiles == '0);
    geom.rows        = rows;
    geom.col_step    = col_step;
    geom.batch_step  = batch_step;
    geom.restart     = hit;
    geom.restart_rem = (cfg_index == tbmt_pkg::CFG_COLS) ?
                       (cols_c < tbmt_pkg::COLS_W'(TILE_COLS)) : (full_tiles == '0);
  end

endmodule
`default_nettype wire

@@ hw/rtl/tbmt_walk.sv @@
`default_nettype none
module tbmt_walk #(
  parameter int TILE_ROWS = 32,
  parameter int TILE_COLS = 32,
  parameter int WORD_BITS = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire tbmt_pkg::geom_t                          geom,
  input  wire logic                                     accept,
  input  wire tbmt_pkg::cmd_t                           cmd,
  output logic                                          ram_we,
  output logic                                          ram_re,
  output logic [$clog2(TILE_ROWS*TILE_COLS)-1:0]        ram_addr,
  output logic [WORD_BITS-1:0]                          ram_wdata,
  output tbmt_pkg::meta_t                               meta
);

  localparam int RW = $clog2(TILE_ROWS);
  localparam int CW = $clog2(TILE_COLS);
  localparam int AW = $clog2(TILE_ROWS*TILE_COLS);
  localparam int DW = tbmt_pkg::DEST_W;

  localparam logic RESET_REM = (32 < TILE_COLS);

  logic                          draining, draining_next;
  logic                          rem_pass, rem_pass_next;
  logic [tbmt_pkg::BIDX_W-1:0]   batch_idx, batch_idx_next;
  logic [tbmt_pkg::FULL_W-1:0]   col_tile_idx, col_tile_idx_next;
  logic [tbmt_pkg::RTIDX_W-1:0]  row_tile_idx, row_tile_idx_next;
  logic [RW-1:0]                 in_row, in_row_next;
  logic [CW-1:0]                 in_col, in_col_next;
  logic [DW-1:0]                 batch_base, batch_base_next;
  logic [DW-1:0]                 col_base, col_base_next;
  logic [DW-1:0]                 col_off, col_off_next;
  logic [tbmt_pkg::ROWS_W-1:0]   row_off, row_off_next;

  logic [tbmt_pkg::TW_W-1:0]     width;
  logic [tbmt_pkg::TW_W-1:0]     col_inc;
  logic                          row_end;
  logic                          col_end;

  assign width    = rem_pass ? tbmt_pkg::TW_W'(geom.rem_width) : tbmt_pkg::TW_W'(TILE_COLS);
  assign col_inc  = tbmt_pkg::TW_W'(in_col) + tbmt_pkg::TW_W'(1);
  assign col_end  = (col_inc >= width);
  assign row_end  = (in_row == RW'(TILE_ROWS - 1));
  assign ram_addr = AW'(in_row) * AW'(TILE_COLS) + AW'(in_col);
  assign ram_wdata = WORD_BITS'(cmd.value);

  always_comb begin
    draining_next     = draining;
    rem_pass_next     = rem_pass;
    batch_idx_next    = batch_idx;
    col_tile_idx_next = col_tile_idx;
    row_tile_idx_next = row_tile_idx;
    in_row_next       = in_row;
    in_col_next       = in_col;
    batch_base_next   = batch_base;
    col_base_next     = col_base;
    col_off_next      = col_off;
    row_off_next      = row_off;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    meta.status         = tbmt_pkg::ST_STORED;
    meta.dest_index     = '0;
    meta.last_of_tile   = 1'b0;
    meta.last_of_tensor = 1'b0;

    if (cmd.command == tbmt_pkg::CMD_DATA) begin
      if (draining) begin
        meta.status = tbmt_pkg::ST_REFUSED;
      end else begin
        meta.status = tbmt_pkg::ST_STORED;
        ram_we      = accept;
        if (col_end) begin
          in_col_next = '0;
          if (row_end) begin
            in_row_next   = '0;
            draining_next = 1'b1;
          end else begin
            in_row_next = in_row + RW'(1);
          end
        end else begin
          in_col_next = in_col + CW'(1);
        end
      end
    end else if (!draining) begin
      meta.status = tbmt_pkg::ST_EMPTY;
    end else begin
      meta.status     = tbmt_pkg::ST_OUT;
      ram_re          = accept;
      meta.dest_index = batch_base + col_base + col_off +
                        DW'(row_off + tbmt_pkg::ROWS_W'(in_row));
      if (row_end) begin
        in_row_next  = '0;
        col_off_next = col_off + DW'(geom.rows);
        if (col_end) begin
          in_col_next       = '0;
          col_off_next      = '0;
          draining_next     = 1'b0;
          meta.last_of_tile = 1'b1;
          // advance to the next tile
          if (tbmt_pkg::RTILES_W'(row_tile_idx) + tbmt_pkg::RTILES_W'(1) < geom.row_tiles)
          begin
            row_tile_idx_next = row_tile_idx + tbmt_pkg::RTIDX_W'(1);
            row_off_next      = row_off + tbmt_pkg::ROWS_W'(TILE_ROWS);
          end else begin
            row_tile_idx_next = '0;
            row_off_next      = '0;
            if (!rem_pass && (col_tile_idx + tbmt_pkg::FULL_W'(1) < geom.full_tiles)) begin
              col_tile_idx_next = col_tile_idx + tbmt_pkg::FULL_W'(1);
              col_base_next     = col_base + DW'(geom.col_step);
            end else begin
              col_tile_idx_next = '0;
              if (!rem_pass) begin
                col_base_next = '0;
              end
              if (tbmt_pkg::BATCHES_W'(batch_idx) + tbmt_pkg::BATCHES_W'(1) < geom.batches)
              begin
                batch_idx_next  = batch_idx + tbmt_pkg::BIDX_W'(1);
                batch_base_next = batch_base + DW'(geom.batch_step);
              end else begin
                batch_idx_next  = '0;
                batch_base_next = '0;
                if (!rem_pass && geom.rem_width != '0) begin
                  // remainder tiles start right after the last full column tile
                  rem_pass_next = 1'b1;
                  col_base_next = col_base + DW'(geom.col_step);
                end else begin
                  rem_pass_next       = geom.full_zero;
                  col_base_next       = '0;
                  meta.last_of_tensor = 1'b1;
                end
              end
            end
          end
        end else begin
          in_col_next = in_col + CW'(1);
        end
      end else begin
        in_row_next = in_row + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining     <= 1'b0;
      rem_pass     <= RESET_REM;
      batch_idx    <= '0;
      col_tile_idx <= '0;
      row_tile_idx <= '0;
      in_row       <= '0;
      in_col       <= '0;
      batch_base   <= '0;
      col_base     <= '0;
      col_off      <= '0;
      row_off      <= '0;
    end else if (geom.restart) begin
      draining     <= 1'b0;
      rem_pass     <= geom.restart_rem;
      batch_idx    <= '0;
      col_tile_idx <= '0;
      row_tile_idx <= '0;
      in_row       <= '0;
      in_col       <= '0;
      batch_base   <= '0;
      col_base     <= '0;
      col_off      <= '0;
      row_off      <= '0;
    end else if (accept) begin
      draining     <= draining_next;
      rem_pass     <= rem_pass_next;
      batch_idx    <= batch_idx_next;
      col_tile_idx <= col_tile_idx_next;
      row_tile_idx <= row_tile_idx_next;
      in_row       <= in_row_next;
      in_col       <= in_col_next;
      batch_base   <= batch_base_next;
      col_base     <= col_base_next;
      col_off      <= col_off_next;
      row_off      <= row_off_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tiled_batch_matrix_transpose_top.sv @@
// channel   signals                       moves
// cmd       cmd_valid, cmd_ready, cmd      one data or pull request (cmd_t)
// res       res_valid, res_ready, res      one result per request (res_t)
// cfg       cfg_we, cfg_index, cfg_data    register write, no handshake
//
// one request accepted per cycle while cmd_ready is high; its result goes
// through the registered store read, then the output register
// synchronous active-high reset; tile store contents are not cleared
// a stalled result holds the stage behind it; cmd_ready drops only when
// both the read stage and the output register are full
`default_nettype none
module tiled_batch_matrix_transpose_top #(
  parameter int TILE_ROWS = 32,
  parameter int TILE_COLS = 32,
  parameter int WORD_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_ready,
  input  wire tbmt_pkg::cmd_t                  cmd,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output tbmt_pkg::res_t                       res,
  input  wire logic                            cfg_we,
  input  wire logic [tbmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbmt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = TILE_ROWS * TILE_COLS;
  localparam int AW    = $clog2(DEPTH);

  tbmt_pkg::geom_t  geom;
  tbmt_pkg::meta_t  meta;
  tbmt_pkg::meta_t  s1_meta;
  logic             s1_valid;
  logic             s1_adv;
  logic             take;
  logic             accept;

  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  // handshake: stage 1 moves on when the output register is free or drained
  assign s1_adv    = !res_valid || res_ready;
  assign take      = s1_valid && s1_adv;
  assign cmd_ready = !s1_valid || s1_adv;
  assign accept    = cmd_valid && cmd_ready;

  // register file and derived tensor geometry
  tbmt_cfg #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // tile traversal, store address and output index counters
  tbmt_walk #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS),
    .WORD_BITS (WORD_BITS)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .accept    (accept),
    .cmd       (cmd),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .meta      (meta)
  );

  // tile store; read data holds while stage 1 is stalled
  tbmt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // stage 1: request info alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.status         <= s1_meta.status;
      res.dest_index     <= s1_meta.dest_index;
      res.last_of_tile   <= s1_meta.last_of_tile;
      res.last_of_tensor <= s1_meta.last_of_tensor;
      // only an element out carries a word
      if (s1_meta.status == tbmt_pkg::ST_OUT) begin
        res.value_res <= tbmt_pkg::VAL_W'(ram_rdata);
      end else begin
        res.value_res <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import tbmt_pkg::*;

  // tile shape of the instance under test
  localparam int TR = 32;
  localparam int TC = 32;

  // shaped random requests to issue after the long tensor
  localparam int unsigned RANDOM_REQS = 300;

  // worst run: ~3500 requests, each waiting out the longest gap on both
  // sides plus the two-stage pipe, taken about eight times over
  localparam int unsigned LIMIT = 1_500_000;

  // register index past the end of the list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tiled_batch_matrix_transpose_top #(
    .TILE_ROWS(TR),
    .TILE_COLS(TC),
    .WORD_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------
  // transpose predictor: own copy of registers, tile walker and store
  // ---------------------------------------------------------------------
  logic [VAL_W-1:0]     tile_words [TR*TC];
  logic [BATCHES_W-1:0] n_batches;
  logic [RTILES_W-1:0]  n_rtiles;
  logic [COLS_W-1:0]    n_cols;
  bit                   draining;
  bit                   rem_pass;
  int unsigned          b_idx, ct_idx, rt_idx, row_in, col_in;

  function automatic int unsigned full_cnt();
    return n_cols / TC;
  endfunction

  function automatic int unsigned rem_cnt();
    return n_cols % TC;
  endfunction

  // back to the first tile of the tensor, filling; store is untouched
  function automatic void walk_restart();
    draining = 1'b0;
    rem_pass = (full_cnt() == 0);
    b_idx = 0;
    ct_idx = 0;
    rt_idx = 0;
    row_in = 0;
    col_in = 0;
  endfunction

  // register write with clamping into the legal range
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    bit hit;
    hit = 1'b1;
    case (idx)
      CFG_BATCHES: begin
        n_batches = (d == 0) ? 11'd1 : (d > 1024) ? 11'd1024 : d[BATCHES_W-1:0];
      end
      CFG_ROW_TILES: begin
        n_rtiles = (d == 0) ? 8'd1 : (d > 128) ? 8'd128 : d[RTILES_W-1:0];
      end
      CFG_COLS: begin
        n_cols = (d == 0) ? 13'd1 : (d > 4096) ? 13'd4096 : d;
      end
      default: hit = 1'b0;
    endcase
    if (hit) walk_restart();
  endfunction

  // one request in, its result out; advances the walker
  function automatic res_t transpose_step(cmd_t c);
    res_t r;
    int unsigned width;
    longint unsigned nrows, cbase, d;
    r = '0;
    width = rem_pass ? rem_cnt() : TC;
    if (c.command == CMD_DATA) begin
      if (draining) begin
        r.status = ST_REFUSED;
      end else begin
        // row-major fill
        r.status = ST_STORED;
        tile_words[row_in * TC + col_in] = c.value;
        col_in++;
        if (col_in >= width) begin
          col_in = 0;
          row_in++;
          if (row_in >= TR) begin
            row_in = 0;
            draining = 1'b1;
          end
        end
      end
    end else if (!draining) begin
      r.status = ST_EMPTY;
    end else begin
      // column-major drain, index into batches x cols x rows
      nrows = longint'(n_rtiles) * TR;
      cbase = longint'(rem_pass ? full_cnt() : ct_idx) * TC;
      d = longint'(b_idx) * n_cols * nrows + (cbase + col_in) * nrows
          + longint'(rt_idx) * TR + row_in;
      r.status = ST_OUT;
      r.value_res = tile_words[row_in * TC + col_in];
      r.dest_index = d[DEST_W-1:0];
      row_in++;
      if (row_in >= TR) begin
        row_in = 0;
        col_in++;
        if (col_in >= width) begin
          col_in = 0;
          draining = 1'b0;
          r.last_of_tile = 1'b1;
          // next tile: row tiles innermost, then column tiles, then batches
          rt_idx++;
          if (rt_idx >= n_rtiles) begin
            rt_idx = 0;
            if (!rem_pass) ct_idx++;
            if (rem_pass || ct_idx >= full_cnt()) begin
              ct_idx = 0;
              b_idx++;
              if (b_idx >= n_batches) begin
                b_idx = 0;
                if (!rem_pass && rem_cnt() != 0) begin
                  rem_pass = 1'b1;
                end else begin
                  rem_pass = (full_cnt() == 0);
                  r.last_of_tensor = 1'b1;
                end
              end
            end
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // scoreboard: results owed in request order
  // ---------------------------------------------------------------------
  res_t        owed_results [$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          pin_valid;
  res_t        pin_res;

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst) begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      // accepted request: run the predictor, a pinned row overrides its answer
      if (cmd_valid && cmd_ready) begin
        want = transpose_step(cmd);
        if (pin_valid) want = pin_res;
        owed_results.push_back(want);
      end
      // accepted result: compare against the oldest owed one
      if (res_valid && res_ready) begin
        got = res;
        if (owed_results.size() == 0) begin
          note_mismatch("result with nothing owed, status", '0, got.status);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status)
            note_mismatch("status", want.status, got.status);
          if (got.value_res !== want.value_res)
            note_mismatch("value_res", want.value_res, got.value_res);
          if (got.dest_index !== want.dest_index)
            note_mismatch("dest_index", want.dest_index, got.dest_index);
          if (got.last_of_tile !== want.last_of_tile)
            note_mismatch("last_of_tile", want.last_of_tile, got.last_of_tile);
          if (got.last_of_tensor !== want.last_of_tensor)
            note_mismatch("last_of_tensor", want.last_of_tensor, got.last_of_tensor);
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // clock, idling and drive helpers
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  bit cmd_quiet;
  bit res_quiet;

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 65) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // result side stalls, changed on the falling edge only
  initial begin
    int unsigned stall;
    stall = 0;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_ready <= 1'b0;
        stall--;
      end else begin
        res_ready <= 1'b1;
        stall = pick_gap(res_quiet);
      end
    end
  end

  // one request; valid stays up across back-to-back requests
  task automatic send_req(input cmd_t c, input bit pin, input res_t pres);
    int unsigned gap;
    gap = pick_gap(cmd_quiet);
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd <= c;
    pin_valid <= pin;
    pin_res <= pres;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic settle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random payload, with all-zero and all-one words mixed in
  function automatic cmd_t mk_req(input logic op);
    cmd_t c;
    int unsigned roll;
    roll = $urandom_range(0, 15);
    c.command = op;
    c.value = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom();
    return c;
  endfunction

  int unsigned shaped_reqs;

  // fill with `words` data requests, then `pulls` pull requests;
  // stray pulls while filling and stray data while draining are mixed in
  task automatic push_tile(input int unsigned words, input int unsigned pulls);
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 9) == 0) send_req(mk_req(CMD_PULL), 1'b0, '0);
      send_req(mk_req(CMD_DATA), 1'b0, '0);
      shaped_reqs++;
    end
    for (int i = 0; i < pulls; i++) begin
      if ($urandom_range(0, 9) == 0) send_req(mk_req(CMD_DATA), 1'b0, '0);
      send_req(mk_req(CMD_PULL), 1'b0, '0);
      shaped_reqs++;
    end
  endtask

  // one geometry: full tiles in walk order, sometimes past the tensor wrap,
  // then maybe a tile cut short by the next register write
  task automatic random_phase(input bit big);
    int unsigned nb, nrt, nc, tiles, per_tensor, full_run, w, roll, cut;
    if (big) begin
      // one full column tile plus a one-column remainder
      nb = 1;
      nrt = 1;
      nc = TC + 1;
    end else begin
      roll = $urandom_range(0, 9);
      nb = $urandom_range(1, 3);
      nrt = $urandom_range(1, 2);
      if (roll < 4) begin
        nc = 1;
      end else if (roll < 8) begin
        nc = $urandom_range(2, 4);
      end else begin
        // wide remainder tile, keep the tensor to a single tile
        nc = $urandom_range(5, TC - 1);
        nb = 1;
        nrt = 1;
      end
    end
    settle();
    cmd_quiet = ($urandom_range(0, 3) == 0);
    res_quiet = ($urandom_range(0, 3) == 0);
    write_reg(CFG_BATCHES, CFG_DATA_W'(nb));
    write_reg(CFG_ROW_TILES, CFG_DATA_W'(nrt));
    write_reg(CFG_COLS, CFG_DATA_W'(nc));
    full_run = (nc / TC) * nrt * nb;
    per_tensor = full_run + ((nc % TC != 0) ? nrt * nb : 0);
    tiles = (big || nc > 4) ? per_tensor : $urandom_range(1, per_tensor + 1);
    for (int t = 0; t < tiles; t++) begin
      w = ((t % per_tensor) < full_run) ? TC : nc % TC;
      push_tile(w * TR, w * TR);
    end
    if (!big && $urandom_range(0, 1) == 1) begin
      w = ((tiles % per_tensor) < full_run) ? TC : nc % TC;
      cut = $urandom_range(1, w * TR - 1);
      if ($urandom_range(0, 1) == 1) push_tile(cut, 0);
      else push_tile(w * TR, cut);
    end
  endtask

  // ---------------------------------------------------------------------
  // opening rows: a register write or a request; a pinned row carries its
  // expected status, all other result fields zero
  // ---------------------------------------------------------------------
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  command;
    logic [VAL_W-1:0]      value;
    bit                    pinned;
    logic [1:0]            pin_status;
  } step_row_t;

  localparam int N_OPEN = 24;
  localparam step_row_t OPENING_ROWS [N_OPEN] = '{
    // after reset: full column pass, width 32, nothing filled yet
    '{1'b0, '0, '0, CMD_PULL, 32'h0000_0000, 1'b1, ST_EMPTY},
    '{1'b0, '0, '0, CMD_DATA, 32'h0000_0000, 1'b1, ST_STORED},
    '{1'b0, '0, '0, CMD_DATA, 32'hFFFF_FFFF, 1'b1, ST_STORED},
    '{1'b0, '0, '0, CMD_DATA, 32'h8000_0001, 1'b0, ST_STORED},
    '{1'b0, '0, '0, CMD_PULL, 32'hFFFF_FFFF, 1'b1, ST_EMPTY},
    // index past the list: no restart, fill goes on
    '{1'b1, CFG_UNUSED, 13'h1FFF, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b0, '0, '0, CMD_DATA, 32'h7FFF_FFFE, 1'b0, ST_STORED},
    // out of range values clamp: low end up, high end down
    '{1'b1, CFG_BATCHES,   13'h0000, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b1, CFG_ROW_TILES, 13'h1FFF, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b1, CFG_COLS,      13'h1FFF, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b0, '0, '0, CMD_DATA, 32'h5555_AAAA, 1'b0, ST_STORED},
    '{1'b0, '0, '0, CMD_PULL, 32'h0, 1'b1, ST_EMPTY},
    '{1'b1, CFG_BATCHES,   13'h1FFF, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b1, CFG_ROW_TILES, 13'h0000, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    // zero columns clamps to one: remainder pass from the start
    '{1'b1, CFG_COLS,      13'h0000, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b0, '0, '0, CMD_DATA, 32'h0000_0000, 1'b1, ST_STORED},
    '{1'b0, '0, '0, CMD_PULL, 32'h0, 1'b1, ST_EMPTY},
    // exact upper bounds
    '{1'b1, CFG_BATCHES,   13'd1024, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b1, CFG_ROW_TILES, 13'd128,  CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b1, CFG_COLS,      13'd4096, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b0, '0, '0, CMD_DATA, 32'hFFFF_FFFF, 1'b1, ST_STORED},
    // exact lower bounds
    '{1'b1, CFG_COLS,      13'd1, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b1, CFG_BATCHES,   13'd1, CMD_DATA, 32'h0, 1'b0, ST_STORED},
    '{1'b1, CFG_ROW_TILES, 13'd1, CMD_DATA, 32'h0, 1'b0, ST_STORED}
  };

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    step_row_t row;
    cmd_t      c;
    res_t      pres;
    // every input known from the first step
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pin_valid = 1'b0;
    pin_res = '0;
    cmd_quiet = 1'b0;
    res_quiet = 1'b0;
    mismatches = 0;
    cycles = 0;
    shaped_reqs = 0;
    // predictor reset values
    n_batches = 11'd1;
    n_rtiles = 8'd1;
    n_cols = 13'd32;
    walk_restart();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // opening rows; register writes only once the pipe is empty
    for (int i = 0; i < N_OPEN; i++) begin
      row = OPENING_ROWS[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        c.command = row.command;
        c.value = row.value;
        pres = '0;
        pres.status = row.pin_status;
        send_req(c, row.pinned, pres);
      end
    end

    // one tensor through both passes, then a few small geometries
    random_phase(1'b1);
    shaped_reqs = 0;
    while (shaped_reqs < RANDOM_REQS) random_phase(1'b0);

    // drain, then idle to catch stray results
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ tiled_batch_matrix_transpose_top.f @@
hw/rtl/tbmt_pkg.sv
hw/rtl/tbmt_ram.sv
hw/rtl/tbmt_cfg.sv
hw/rtl/tbmt_walk.sv
hw/rtl/tiled_batch_matrix_transpose_top.sv
bench/tb.sv
